// ===== sv/aes_pkg.sv =====
// Package with AES-256-CTR types, constants and round functions.
package aes_pkg;

  localparam int unsigned NumRkWords = 60;
  localparam int unsigned RkAw = 6;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgAw = 2;

  localparam logic OpLoadCtr = 1'b0;
  localparam logic OpData = 1'b1;

  // One queued transaction between the front and the back part.
  typedef struct packed {
    logic        op;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    logic [4:0]  nbytes;
  } item_t;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_RUN
  } kx_state_e;

  typedef enum logic [1:0] {
    CE_IDLE,
    CE_ROUND,
    CE_OUT
  } ce_state_e;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] t);
    return {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte k sits at bits 127-8k; column c holds bytes 4c..4c+3.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = sbox(s[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

// ===== sv/aes256_ctr_stream_cipher_unit.sv =====
// Top level of the AES-256 counter-mode stream cipher.
//
// Usage: write the four 64-bit key words through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle. Each write restarts the key expansion,
// which fills the 60-word round-key memory word by word; data waits for it.
// Input transactions arrive on s_axis: tuser is op (0 loads the 128-bit
// counter from tdata, 1 enciphers a data block). tdata holds block_hi,
// block_lo and valid_bytes. A data block gives one output transaction on
// m_axis with the masked result and the byte count; a count of zero gives
// nothing and a count above sixteen is taken as sixteen.
// Sequence: 15 round keys are fetched four words each over the single read
// port of the round-key memory, and each is applied once it is complete.
// Blocks run one at a time: the core takes no new block from the queue until
// the last result is taken; a counter load is applied while it is idle.
// A two-entry queue takes further items meanwhile.
// Reset clears the counter, the key words and the queue; the round-key
// memory holds nothing valid until a key word is written.
// When the receiver stalls, the result holds and the counter advances only
// once it is taken; the queue then fills and s_axis_tready falls.
module aes256_ctr_stream_cipher_unit import aes_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: block_hi [63:0], block_lo [127:64], valid_bytes [132:128], zeros
  input  logic [135:0] s_axis_tdata,
  // tuser: op [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_hi [63:0], out_lo [127:64], out_valid_bytes [132:128], zeros
  output logic [135:0] m_axis_tdata
);

  item_t in_item, q_item;
  logic q_valid, q_ready, kx_busy, rk_we;
  logic [RkAw-1:0] rk_waddr, rk_raddr;
  logic [31:0] rk_wdata, rk_rdata;
  logic [63:0] o_hi, o_lo;
  logic [4:0] o_nb;

  assign in_item.op = s_axis_tuser;
  assign in_item.blk_hi = s_axis_tdata[63:0];
  assign in_item.blk_lo = s_axis_tdata[127:64];
  assign in_item.nbytes = s_axis_tdata[132:128];

  aes_keyexp u_kx (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i(cfg_idx_i[CfgAw-1:0]), .cfg_hit_i(1'b1),
    .cfg_data_i, .busy_o(kx_busy), .rk_we_o(rk_we), .rk_waddr_o(rk_waddr),
    .rk_wdata_o(rk_wdata)
  );

  aes_ram #(.Width(32), .Depth(NumRkWords)) u_rk (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rk_wdata),
    .raddr_i(rk_raddr), .rdata_o(rk_rdata)
  );

  aes_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  aes_core u_core (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .kx_busy_i(kx_busy), .rk_raddr_o(rk_raddr), .rk_rdata_i(rk_rdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_hi_o(o_hi), .out_lo_o(o_lo), .out_nbytes_o(o_nb)
  );

  assign m_axis_tdata = {3'b000, o_nb, o_lo, o_hi};

endmodule

// ===== sv/aes_ram.sv =====
// Generic single-port-write RAM with one registered read port.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/aes_keyexp.sv =====
// Key register file and sequential round-key expansion, one word a cycle.
module aes_keyexp import aes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgAw-1:0]  cfg_idx_i,
  input  logic              cfg_hit_i,
  input  logic [63:0]       cfg_data_i,
  output logic              busy_o,
  output logic              rk_we_o,
  output logic [RkAw-1:0]   rk_waddr_o,
  output logic [31:0]       rk_wdata_o
);

  logic [63:0] key_q [NumKeyRegs];
  // Sliding window of the last eight expanded words; win_q[7] is the newest.
  logic [31:0] win_q [8];
  logic [31:0] win_d [8];
  logic [RkAw-1:0] idx_q, idx_d;
  kx_state_e state_q, state_d;
  logic [31:0] t, nw;
  logic [2:0] rc_i;
  logic [7:0] rc;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeyRegs; i++) key_q[i] <= '0;
    end else if (cfg_we_i && cfg_hit_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KX_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) win_q[i] <= win_d[i];
  end

  // New word from the window.
  always_comb begin
    rc_i = idx_q[5:3];
    unique case (rc_i)
      3'd1: rc = 8'h01; 3'd2: rc = 8'h02; 3'd3: rc = 8'h04; 3'd4: rc = 8'h08;
      3'd5: rc = 8'h10; 3'd6: rc = 8'h20; 3'd7: rc = 8'h40;
      default: rc = 8'h00;
    endcase
    t = win_q[7];
    if (idx_q[2:0] == 3'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
    end else if (idx_q[2:0] == 3'd4) begin
      t = sub_word(t);
    end
    nw = win_q[0] ^ t;
  end

  // Sequencer: a write restarts expansion from the key registers as written.
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    for (int i = 0; i < 8; i++) win_d[i] = win_q[i];
    rk_we_o = 1'b0;
    rk_waddr_o = idx_q;
    rk_wdata_o = nw;
    unique case (state_q)
      KX_IDLE: ;
      KX_RUN: begin
        if (idx_q < RkAw'(8)) begin
          rk_wdata_o = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
        end
        rk_we_o = 1'b1;
        for (int i = 0; i < 7; i++) win_d[i] = win_q[i+1];
        win_d[7] = rk_wdata_o;
        if (idx_q == RkAw'(NumRkWords - 1)) begin
          state_d = KX_IDLE;
        end
        idx_d = idx_q + 1'b1;
      end
      default: state_d = KX_IDLE;
    endcase
    if (cfg_we_i && cfg_hit_i) begin
      state_d = KX_RUN;
      idx_d = '0;
    end
  end

  assign busy_o = (state_q == KX_RUN);

  ap_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_we_o |-> rk_waddr_o < RkAw'(NumRkWords)) else $error("round key address out of range");
  ap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && idx_q == RkAw'(NumRkWords - 1) && !cfg_we_i) |=> !busy_o)
    else $error("expansion did not stop");
  ap_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_hit_i) |=> (busy_o && idx_q == '0)) else $error("no restart");

endmodule

// ===== sv/aes_front.sv =====
// Front part: input skid-free queue of two entries that holds accepted items.
module aes_front import aes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);

  item_t buf_q [2];
  logic [1:0] cnt_q;
  logic rd_q, wr_q;
  logic push, pop, keep;
  item_t push_item;

  // Data items with a zero byte count are dropped at the door.
  assign keep = !(in_item_i.op == OpData && in_item_i.nbytes == 5'd0);
  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o && keep;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  // Saturate the byte count on entry.
  always_comb begin
    push_item = in_item_i;
    if (in_item_i.nbytes > 5'd16) push_item.nbytes = 5'd16;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= push_item;
    end
  end

  ap_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !in_ready_o) else $error("push into full queue");
  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  ap_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && q_item_o.op == OpData) |-> q_item_o.nbytes != 5'd0)
    else $error("zero count item queued");

endmodule

// ===== sv/aes_core.sv =====
// Back part: counter register, sequential AES rounds, keystream XOR and output.
module aes_core import aes_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  item_t           q_item_i,
  input  logic            kx_busy_i,
  output logic [RkAw-1:0] rk_raddr_o,
  input  logic [31:0]     rk_rdata_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     out_hi_o,
  output logic [63:0]     out_lo_o,
  output logic [4:0]      out_nbytes_o
);

  ce_state_e state_q, state_d;
  logic [127:0] ctr_q, ctr_d;
  logic [127:0] st_q, st_d;
  logic [127:0] rk_q, rk_d;
  logic [127:0] dat_q;
  logic [4:0] nb_q;
  // Round counter and word counter for key fetch.
  logic [3:0] rnd_q, rnd_d;
  logic [1:0] wc_q, wc_d;
  logic [3:0] fr_q, fr_d;
  logic fetch_q, fetch_d;
  logic have_q, have_d;
  logic load_dat;
  logic [127:0] ks, msk, res;
  logic [127:0] rnd_out;

  // A round key is four words, fetched one word a cycle at addr 4r+c; the
  // registered read returns each word in the next cycle.
  assign rk_raddr_o = RkAw'({fr_q, wc_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CE_IDLE;
      ctr_q <= '0;
      rnd_q <= '0;
      wc_q <= '0;
      fr_q <= '0;
      fetch_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q <= ctr_d;
      rnd_q <= rnd_d;
      wc_q <= wc_d;
      fr_q <= fr_d;
      fetch_q <= fetch_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
    if (load_dat) begin
      dat_q <= {q_item_i.blk_hi, q_item_i.blk_lo};
      nb_q <= q_item_i.nbytes;
    end
  end

  always_comb begin
    rnd_out = sub_shift(st_q);
    if (rnd_q != 4'd14) rnd_out = mix(rnd_out);
    ks = st_q;
    for (int k = 0; k < 16; k++) begin
      msk[127 - 8*k -: 8] = (5'(k) < nb_q) ? 8'hff : 8'h00;
    end
    res = (dat_q ^ ks) & msk;
  end

  // Sequencer: a counter load, or for a data block fetch round key r, then apply it.
  always_comb begin
    state_d = state_q;
    ctr_d = ctr_q;
    st_d = st_q;
    rk_d = rk_q;
    rnd_d = rnd_q;
    wc_d = wc_q;
    fr_d = fr_q;
    fetch_d = 1'b0;
    have_d = 1'b0;
    load_dat = 1'b0;
    q_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      CE_IDLE: begin
        if (q_valid_i && !kx_busy_i) begin
          q_ready_o = 1'b1;
          if (q_item_i.op == OpLoadCtr) begin
            ctr_d = {q_item_i.blk_hi, q_item_i.blk_lo};
          end else begin
            load_dat = 1'b1;
            st_d = ctr_q;
            rnd_d = '0;
            fr_d = '0;
            wc_d = '0;
            fetch_d = 1'b1;
            state_d = CE_ROUND;
          end
        end
      end
      CE_ROUND: begin
        // Collect the word read last cycle.
        if (have_q) begin
          rk_d = {rk_q[95:0], rk_rdata_i};
        end
        if (fetch_q) begin
          have_d = 1'b1;
          if (wc_q != 2'd3) begin
            wc_d = wc_q + 1'b1;
            fetch_d = 1'b1;
          end else begin
            wc_d = '0;
          end
        end else if (have_q) begin
          // Last word just arrived: apply the round.
          if (rnd_q == 4'd0) begin
            st_d = st_q ^ {rk_q[95:0], rk_rdata_i};
          end else begin
            st_d = rnd_out ^ {rk_q[95:0], rk_rdata_i};
          end
          if (rnd_q == 4'(NumRounds)) begin
            state_d = CE_OUT;
          end else begin
            rnd_d = rnd_q + 1'b1;
            fr_d = rnd_q + 1'b1;
            fetch_d = 1'b1;
          end
        end
      end
      CE_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctr_d = ctr_q + 128'd1;
          state_d = CE_IDLE;
        end
      end
      default: state_d = CE_IDLE;
    endcase
  end

  assign out_hi_o = res[127:64];
  assign out_lo_o = res[63:0];
  assign out_nbytes_o = nb_q;

  ap_ctr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> ctr_q == $past(ctr_q) + 128'd1)
    else $error("counter not advanced");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(res))
    else $error("result changed under stall");
  ap_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 4'(NumRounds)) else $error("round count out of range");

endmodule
